FILE: hdl/gfpw_pkg.sv
package gfpw_pkg;

    localparam int MAX_RADIUS_DEF  = 7;
    localparam int COORD_BITS_DEF  = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int RAD_W     = 4;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGULARIZER  = 2'd3;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STAT  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [11:0] ref_row;
        logic [11:0] ref_col;
        logic [11:0] other_row;
        logic [11:0] other_col;
        logic [47:0] ref_color;
        logic [47:0] other_color;
        logic [47:0] window_mean;
        logic [59:0] cov_diagonal;
        logic [59:0] cov_cross;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] weight;
        logic               overflow_flag;
    } out_item_t;

    // one classified word handed from the front to the back
    typedef struct packed {
        logic             start;
        logic             counted;
        logic             last;
        logic [RAD_W-1:0] radius;
        logic [47:0]      ref_color;
        logic [47:0]      other_color;
        logic [47:0]      window_mean;
        logic [59:0]      cov_diagonal;
        logic [59:0]      cov_cross;
    } job_t;

    typedef struct packed {
        logic        start;
        logic [63:0] rem0;
        logic [63:0] num;
        logic [5:0]  pairs;
        logic [63:0] den;
    } div_req_t;

    // omega squared, (2r+1)^4
    function automatic logic [19:0] omega_sq(input logic [RAD_W-1:0] r);
        logic [4:0] s;
        logic [9:0] s2;
        s  = {r, 1'b1};
        s2 = 10'(s * s);
        return 20'(s2 * s2);
    endfunction

endpackage

FILE: hdl/guided_filter_pair_weight.sv
// Color guided-filter affinity weight between a reference and another pixel.
// Send a start word (func 0) with both positions and colors, then one word
// (func 1) per mask position, raster order over the (2r+1)x(2r+1) offsets,
// with that window's mean and covariance; the last mask word yields one
// result, sum / omega^2 in Q15.32, with overflow_flag for saturation or a
// singular covariance. A front stage classifies words (bounds, last of sweep)
// into a 2-word queue, so it keeps accepting while the back end computes,
// until the queue is full. In the back end a start word or a skipped center
// that is not the last is taken in idle; a counted center uses the one
// shared 46x22 multiplier (27 products, one per cycle) and the shared
// divider retiring 2 quotient bits per cycle for the term; a sweep's end
// also divides by omega^2. Config registers are written via cfg_we/
// cfg_addr/cfg_wdata only while idle, a user rule the block does not enforce.
module guided_filter_pair_weight #(
    parameter int MAX_RADIUS  = gfpw_pkg::MAX_RADIUS_DEF,
    parameter int COORD_BITS  = gfpw_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = gfpw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  gfpw_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output gfpw_pkg::out_item_t             m_data,
    input  logic                            cfg_we,
    input  logic [gfpw_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [gfpw_pkg::CFG_W-1:0]      cfg_wdata
);

    logic [12:0] image_width_reg, image_height_reg;
    logic [2:0]  radius_reg;
    logic [19:0] regularizer_reg;

    logic           fq_valid, fq_ready, bq_valid, bq_ready;
    gfpw_pkg::job_t fq_job, bq_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= 13'd1;
            image_height_reg <= 13'd1;
            radius_reg       <= 3'd1;
            regularizer_reg  <= 20'd262;
        end else if (cfg_we) begin
            case (cfg_addr)
                gfpw_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[12:0];
                gfpw_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[12:0];
                gfpw_pkg::CFG_RADIUS:       radius_reg       <= cfg_wdata[2:0];
                gfpw_pkg::CFG_REGULARIZER:  regularizer_reg  <= cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    gfpw_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .image_width   (image_width_reg),
        .image_height  (image_height_reg),
        .window_radius (radius_reg),
        .job_valid     (fq_valid),
        .job_ready     (fq_ready),
        .job           (fq_job)
    );

    gfpw_fifo #(
        .W     ($bits(gfpw_pkg::job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_job),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_data  (bq_job)
    );

    gfpw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (bq_valid),
        .job_ready   (bq_ready),
        .job         (bq_job),
        .regularizer (regularizer_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

FILE: hdl/gfpw_fifo.sv
module gfpw_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/gfpw_front.sv
module gfpw_front #(
    parameter int MAX_RADIUS = gfpw_pkg::MAX_RADIUS_DEF,
    parameter int COORD_BITS = gfpw_pkg::COORD_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gfpw_pkg::in_item_t s_data,
    input  logic [12:0]       image_width,
    input  logic [12:0]       image_height,
    input  logic [2:0]        window_radius,
    output logic              job_valid,
    input  logic              job_ready,
    output gfpw_pkg::job_t    job
);

    localparam int XW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;

    logic [COORD_BITS-1:0] ref_row_reg, ref_col_reg, oth_row_reg, oth_col_reg;
    logic [3:0]            mask_row_reg, mask_col_reg;

    logic [gfpw_pkg::RAD_W-1:0] rad;
    logic [4:0]                 twor;
    logic signed [XW-1:0]       ki, kj, rs, orw, ocl, hgt, wid;
    logic                       counted, last, accept;

    always_comb begin
        rad = ({1'b0, window_radius} > gfpw_pkg::RAD_W'(MAX_RADIUS))
            ? gfpw_pkg::RAD_W'(MAX_RADIUS) : {1'b0, window_radius};
        twor = {rad, 1'b0};
        rs   = $signed(XW'(rad));
        orw  = $signed(XW'(oth_row_reg));
        ocl  = $signed(XW'(oth_col_reg));
        hgt  = $signed(XW'(image_height));
        wid  = $signed(XW'(image_width));
        ki   = $signed(XW'(ref_row_reg)) + $signed(XW'(mask_row_reg)) - rs;
        kj   = $signed(XW'(ref_col_reg)) + $signed(XW'(mask_col_reg)) - rs;
        counted = (ki >= 0) && (ki < hgt) && (kj >= 0) && (kj < wid)
               && (ki + rs >= orw) && (ki <= orw + rs)
               && (kj + rs >= ocl) && (kj <= ocl + rs);
        last = ({1'b0, mask_row_reg} >= twor) && ({1'b0, mask_col_reg} >= twor);
    end

    assign s_ready   = job_ready;
    assign job_valid = s_valid;
    assign accept    = s_valid && job_ready;

    always_comb begin
        job.start        = (s_data.func == gfpw_pkg::FUNC_START);
        job.counted      = counted;
        job.last         = last;
        job.radius       = rad;
        job.ref_color    = s_data.ref_color;
        job.other_color  = s_data.other_color;
        job.window_mean  = s_data.window_mean;
        job.cov_diagonal = s_data.cov_diagonal;
        job.cov_cross    = s_data.cov_cross;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_row_reg  <= '0;
            ref_col_reg  <= '0;
            oth_row_reg  <= '0;
            oth_col_reg  <= '0;
            mask_row_reg <= '0;
            mask_col_reg <= '0;
        end else if (accept) begin
            if (s_data.func == gfpw_pkg::FUNC_START) begin
                ref_row_reg  <= COORD_BITS'(s_data.ref_row);
                ref_col_reg  <= COORD_BITS'(s_data.ref_col);
                oth_row_reg  <= COORD_BITS'(s_data.other_row);
                oth_col_reg  <= COORD_BITS'(s_data.other_col);
                mask_row_reg <= '0;
                mask_col_reg <= '0;
            end else if (last) begin
                mask_row_reg <= '0;
                mask_col_reg <= '0;
            end else if ({1'b0, mask_col_reg} >= twor) begin
                mask_col_reg <= '0;
                mask_row_reg <= mask_row_reg + 1'b1;
            end else begin
                mask_col_reg <= mask_col_reg + 1'b1;
            end
        end
    end

endmodule

FILE: hdl/gfpw_div.sv
module gfpw_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  gfpw_pkg::div_req_t req,
    output logic               done,
    output logic [63:0]        quo
);

    logic [63:0] rem_reg, sh_reg, den_reg, quo_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg, done_reg;
    logic [63:0] r1, r1s, r2, r2s;
    logic        g1, g2;

    // two restoring steps per cycle
    always_comb begin
        r1  = {rem_reg[62:0], sh_reg[63]};
        g1  = (r1 >= den_reg);
        r1s = g1 ? r1 - den_reg : r1;
        r2  = {r1s[62:0], sh_reg[62]};
        g2  = (r2 >= den_reg);
        r2s = g2 ? r2 - den_reg : r2;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.rem0;
            sh_reg  <= req.num;
            den_reg <= req.den;
            cnt_reg <= req.pairs;
            quo_reg <= '0;
        end else if (run_reg) begin
            rem_reg <= r2s;
            sh_reg  <= {sh_reg[61:0], 2'b00};
            quo_reg <= {quo_reg[61:0], g1, g2};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= run_reg && (cnt_reg == 6'd1) && !req.start;
            if (req.start) begin
                run_reg <= 1'b1;
            end else if (run_reg && cnt_reg == 6'd1) begin
                run_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/gfpw_back.sv
module gfpw_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  gfpw_pkg::job_t      job,
    input  logic [19:0]         regularizer,
    output logic                m_valid,
    input  logic                m_ready,
    output gfpw_pkg::out_item_t m_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_CHK   = 3'd2;
    localparam logic [2:0] ST_DIVQ  = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;
    localparam logic [2:0] ST_DIVF  = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    // result groups of the product sequence
    localparam logic [3:0] G_ADJ00 = 4'd0;
    localparam logic [3:0] G_ADJ11 = 4'd1;
    localparam logic [3:0] G_ADJ22 = 4'd2;
    localparam logic [3:0] G_ADJ01 = 4'd3;
    localparam logic [3:0] G_ADJ02 = 4'd4;
    localparam logic [3:0] G_ADJ12 = 4'd5;
    localparam logic [3:0] G_DET   = 4'd6;
    localparam logic [3:0] G_W0    = 4'd7;
    localparam logic [3:0] G_W1    = 4'd8;
    localparam logic [3:0] G_W2    = 4'd9;
    localparam logic [3:0] G_NUM   = 4'd10;

    localparam logic [4:0] LAST_STEP = 5'd27;

    logic [2:0] state_reg, state_next;
    logic [4:0] step_reg;
    logic [3:0] cgrp_reg;
    logic [1:0] cpos_reg;

    logic [47:0] ref_color_reg, oth_color_reg;
    logic signed [63:0] acc_reg;
    logic               err_reg;
    logic               last_reg;
    logic [gfpw_pkg::RAD_W-1:0] rad_reg;

    logic signed [21:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg;
    logic signed [16:0] av_reg [3];
    logic signed [16:0] bv_reg [3];
    logic signed [45:0] adj00_reg, adj11_reg, adj22_reg, adj01_reg, adj02_reg, adj12_reg;
    logic signed [45:0] w0_reg, w1_reg, w2_reg;
    logic signed [63:0] det_reg, num_reg, tmp_reg, prod_reg;
    logic [51:0]        q_reg;
    logic               neg_reg;

    logic               m_valid_reg;
    gfpw_pkg::out_item_t m_data_reg;

    // load-time operands
    logic signed [21:0] a_in, b_in, c_in, d_in, e_in, f_in, eps;
    logic signed [16:0] av_in [3];
    logic signed [16:0] bv_in [3];

    // product sequence
    logic signed [45:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [67:0] mul_p;
    logic               c_first, c_last, c_sub;
    logic signed [63:0] c_sum;

    logic [63:0] n_abs, d_abs, acc_abs, mag;
    logic        too_big, sat, out_free;
    logic signed [63:0] term, res;
    gfpw_pkg::div_req_t div_req;
    logic               div_done;
    logic [63:0]        div_quo;

    gfpw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        eps  = $signed({2'b00, regularizer});
        a_in = $signed({{2{job.cov_diagonal[19]}}, job.cov_diagonal[19:0]}) + eps;
        b_in = $signed({{2{job.cov_diagonal[39]}}, job.cov_diagonal[39:20]}) + eps;
        c_in = $signed({{2{job.cov_diagonal[59]}}, job.cov_diagonal[59:40]}) + eps;
        d_in = $signed({{2{job.cov_cross[19]}}, job.cov_cross[19:0]});
        e_in = $signed({{2{job.cov_cross[39]}}, job.cov_cross[39:20]});
        f_in = $signed({{2{job.cov_cross[59]}}, job.cov_cross[59:40]});
        for (int k = 0; k < 3; k++) begin
            av_in[k] = $signed({1'b0, ref_color_reg[16*k +: 16]})
                     - $signed({1'b0, job.window_mean[16*k +: 16]});
            bv_in[k] = $signed({1'b0, oth_color_reg[16*k +: 16]})
                     - $signed({1'b0, job.window_mean[16*k +: 16]});
        end
    end

    // operand select for the product issued at this step
    always_comb begin
        case (step_reg)
            5'd0:    begin mul_a = 46'(b_reg); mul_b = c_reg; end
            5'd1:    begin mul_a = 46'(f_reg); mul_b = f_reg; end
            5'd2:    begin mul_a = 46'(a_reg); mul_b = c_reg; end
            5'd3:    begin mul_a = 46'(e_reg); mul_b = e_reg; end
            5'd4:    begin mul_a = 46'(a_reg); mul_b = b_reg; end
            5'd5:    begin mul_a = 46'(d_reg); mul_b = d_reg; end
            5'd6:    begin mul_a = 46'(e_reg); mul_b = f_reg; end
            5'd7:    begin mul_a = 46'(d_reg); mul_b = c_reg; end
            5'd8:    begin mul_a = 46'(d_reg); mul_b = f_reg; end
            5'd9:    begin mul_a = 46'(e_reg); mul_b = b_reg; end
            5'd10:   begin mul_a = 46'(d_reg); mul_b = e_reg; end
            5'd11:   begin mul_a = 46'(a_reg); mul_b = f_reg; end
            5'd12:   begin mul_a = adj00_reg >>> 12; mul_b = a_reg; end
            5'd13:   begin mul_a = adj01_reg >>> 12; mul_b = d_reg; end
            5'd14:   begin mul_a = adj02_reg >>> 12; mul_b = e_reg; end
            5'd15:   begin mul_a = adj00_reg; mul_b = 22'(bv_reg[0]); end
            5'd16:   begin mul_a = adj01_reg; mul_b = 22'(bv_reg[1]); end
            5'd17:   begin mul_a = adj02_reg; mul_b = 22'(bv_reg[2]); end
            5'd18:   begin mul_a = adj01_reg; mul_b = 22'(bv_reg[0]); end
            5'd19:   begin mul_a = adj11_reg; mul_b = 22'(bv_reg[1]); end
            5'd20:   begin mul_a = adj12_reg; mul_b = 22'(bv_reg[2]); end
            5'd21:   begin mul_a = adj02_reg; mul_b = 22'(bv_reg[0]); end
            5'd22:   begin mul_a = adj12_reg; mul_b = 22'(bv_reg[1]); end
            5'd23:   begin mul_a = adj22_reg; mul_b = 22'(bv_reg[2]); end
            5'd24:   begin mul_a = w0_reg; mul_b = 22'(av_reg[0]); end
            5'd25:   begin mul_a = w1_reg; mul_b = 22'(av_reg[1]); end
            5'd26:   begin mul_a = w2_reg; mul_b = 22'(av_reg[2]); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;
    end

    // fold the previous product into its group: adjugate pairs subtract
    always_comb begin
        c_first = (cpos_reg == 2'd0);
        c_sub   = (cgrp_reg < G_DET) && (cpos_reg == 2'd1);
        c_last  = (cgrp_reg < G_DET) ? (cpos_reg == 2'd1) : (cpos_reg == 2'd2);
        c_sum   = c_sub ? (c_first ? 64'sd0 : tmp_reg) - prod_reg
                        : (c_first ? 64'sd0 : tmp_reg) + prod_reg;
    end

    always_comb begin
        n_abs   = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
        d_abs   = det_reg[63] ? 64'(-det_reg) : 64'(det_reg);
        acc_abs = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
        too_big = ({16'b0, n_abs} >= {d_abs[53:0], 26'b0});
        term    = neg_reg ? -$signed({12'b0, q_reg}) : $signed({12'b0, q_reg});

        div_req.start = 1'b0;
        div_req.rem0  = '0;
        div_req.num   = '0;
        div_req.pairs = '0;
        div_req.den   = '0;
        if (state_reg == ST_CHK && det_reg != 0 && !too_big) begin
            div_req.start = 1'b1;
            div_req.rem0  = {26'b0, n_abs[63:26]};
            div_req.num   = {n_abs[25:0], 38'b0};
            div_req.pairs = 6'd26;
            div_req.den   = d_abs;
        end else if (state_reg == ST_FINAL) begin
            div_req.start = 1'b1;
            div_req.num   = acc_abs;
            div_req.pairs = 6'd32;
            div_req.den   = {44'b0, gfpw_pkg::omega_sq(rad_reg)};
        end

        sat = 1'b0;
        mag = div_quo;
        if (acc_reg[63]) begin
            if (mag > 64'h0000_8000_0000_0000) begin
                mag = 64'h0000_8000_0000_0000;
                sat = 1'b1;
            end
            res = -$signed(mag);
        end else begin
            if (mag > 64'h0000_7FFF_FFFF_FFFF) begin
                mag = 64'h0000_7FFF_FFFF_FFFF;
                sat = 1'b1;
            end
            res = $signed(mag);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid && !job.start) begin
                    if (job.counted) begin
                        state_next = ST_MUL;
                    end else if (job.last) begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_MUL: begin
                if (step_reg == LAST_STEP) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                state_next = (det_reg == 0 || too_big) ? ST_ACC : ST_DIVQ;
            end
            ST_DIVQ: begin
                if (div_done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                state_next = last_reg ? ST_FINAL : ST_IDLE;
            end
            ST_FINAL: begin
                state_next = ST_DIVF;
            end
            ST_DIVF: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && job_valid && !job.start) begin
            a_reg    <= a_in;
            b_reg    <= b_in;
            c_reg    <= c_in;
            d_reg    <= d_in;
            e_reg    <= e_in;
            f_reg    <= f_in;
            av_reg   <= av_in;
            bv_reg   <= bv_in;
            last_reg <= job.last;
            rad_reg  <= job.radius;
            step_reg <= '0;
            cgrp_reg <= G_ADJ00;
            cpos_reg <= '0;
        end
        if (state_reg == ST_MUL) begin
            step_reg <= step_reg + 1'b1;
            prod_reg <= 64'(mul_p);
            if (step_reg != 5'd0) begin
                tmp_reg <= c_sum;
                if (c_last) begin
                    cgrp_reg <= cgrp_reg + 1'b1;
                    cpos_reg <= '0;
                end else begin
                    cpos_reg <= cpos_reg + 1'b1;
                end
                if (c_last) begin
                    case (cgrp_reg)
                        G_ADJ00: adj00_reg <= 46'(c_sum);
                        G_ADJ11: adj11_reg <= 46'(c_sum);
                        G_ADJ22: adj22_reg <= 46'(c_sum);
                        G_ADJ01: adj01_reg <= 46'(c_sum);
                        G_ADJ02: adj02_reg <= 46'(c_sum);
                        G_ADJ12: adj12_reg <= 46'(c_sum);
                        G_DET:   det_reg   <= c_sum;
                        G_W0:    w0_reg    <= 46'(c_sum >>> 20);
                        G_W1:    w1_reg    <= 46'(c_sum >>> 20);
                        G_W2:    w2_reg    <= 46'(c_sum >>> 20);
                        G_NUM:   num_reg   <= c_sum;
                        default: ;
                    endcase
                end
            end
        end
        if (state_reg == ST_CHK) begin
            neg_reg <= num_reg[63] ^ det_reg[63];
            q_reg   <= (det_reg == 0) ? 52'd0 : {52{1'b1}};
        end
        if (state_reg == ST_DIVQ && div_done) begin
            q_reg <= div_quo[51:0];
        end
        // quotient and accumulator hold still until the word is loaded
        if (state_reg == ST_EMIT && out_free) begin
            m_data_reg.weight        <= res[47:0];
            m_data_reg.overflow_flag <= sat || err_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            ref_color_reg <= '0;
            oth_color_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid && job.start) begin
                        ref_color_reg <= job.ref_color;
                        oth_color_reg <= job.other_color;
                        acc_reg       <= '0;
                        err_reg       <= 1'b0;
                    end
                end
                ST_CHK: begin
                    if (det_reg == 0 || too_big) begin
                        err_reg <= 1'b1;
                    end
                end
                ST_ACC: begin
                    acc_reg <= acc_reg + 64'sh1_0000_0000 + term;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        acc_reg <= '0;
                        err_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
